// ===== src/hpt_pkg.sv =====
`timescale 1ns / 1ps

package hpt_pkg;

    localparam int SLOTS_DEFAULT   = 1024;
    localparam int ID_BITS_DEFAULT = 8;
    localparam int KEY_PARTS       = 5;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    // prime is 2^40 + 0x1b3
    localparam int          FNV_SHIFT = 40;
    localparam logic [63:0] FNV_LOW   = 64'h0000_0000_0000_01B3;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int FID_W   = 8;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] dim_m;
        logic [31:0] dim_n;
        logic [31:0] dim_k;
        logic [15:0] thread_count;
        logic [15:0] tile_edge;
        logic [7:0]  kernel_id;
        logic [31:0] now_time;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [FID_W-1:0]   found_id;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
        logic [COUNT_W-1:0] valid_count;
        logic [31:0]        hit_total;
        logic [31:0]        miss_total;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] m;
        logic [31:0] n;
        logic [31:0] k;
        logic [15:0] t;
        logic [15:0] e;
        logic [31:0] stamp;
    } entry_t;

    function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [31:0] part);
        logic [63:0] x;
        x = h ^ {32'd0, part};
        return (x << FNV_SHIFT) + x * FNV_LOW;
    endfunction

endpackage

// ===== src/hpt_front.sv =====
`timescale 1ns / 1ps

module hpt_front #(
    parameter int SLOTS = hpt_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  hpt_pkg::item_t             item,
    output logic                       busy,
    output logic                       job_push,
    output hpt_pkg::item_t             job_item,
    output logic [$clog2(SLOTS)-1:0]   job_home,
    input  logic                       job_full
);
    import hpt_pkg::*;

    localparam int SB = $clog2(SLOTS);

    logic        busy_reg, busy_next;
    logic [2:0]  round_reg, round_next;
    logic [63:0] h_reg, h_next;
    item_t       item_reg;
    logic [31:0] part;
    logic        hash_done;

    assign hash_done = round_reg == 3'(KEY_PARTS);

    always_comb
    begin
        case (round_reg)
            3'd0:    part = item_reg.dim_m;
            3'd1:    part = item_reg.dim_n;
            3'd2:    part = item_reg.dim_k;
            3'd3:    part = {16'd0, item_reg.thread_count};
            3'd4:    part = {16'd0, item_reg.tile_edge};
            default: part = 32'd0;
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        round_next = round_reg;
        h_next     = h_reg;
        job_push   = 1'b0;
        if (!busy_reg)
        begin
            if (push)
            begin
                busy_next  = 1'b1;
                round_next = 3'd0;
                h_next     = FNV_BASIS;
            end
        end
        else if (!hash_done)
        begin
            h_next     = fnv_round(h_reg, part);
            round_next = round_reg + 3'd1;
        end
        else if (!job_full)
        begin
            job_push  = 1'b1;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 3'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        if (!busy_reg && push)
        begin
            item_reg <= item;
        end
    end

    assign busy     = busy_reg;
    assign job_item = item_reg;
    assign job_home = h_reg[SB-1:0];

endmodule

// ===== src/hpt_fifo.sv =====
`timescale 1ns / 1ps

module hpt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         empty
);
    localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB = $clog2(DEPTH + 1);

    logic [W-1:0]  buf_q [DEPTH];
    logic [AB-1:0] wp_reg, rp_reg;
    logic [CB-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign full  = cnt_reg == CB'(DEPTH);
    assign empty = cnt_reg == '0;
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = buf_q[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == AB'(DEPTH - 1)) ? '0 : wp_reg + AB'(1);
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == AB'(DEPTH - 1)) ? '0 : rp_reg + AB'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CB'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CB'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            buf_q[wp_reg] <= wdata;
        end
    end

endmodule

// ===== src/hpt_back.sv =====
`timescale 1ns / 1ps

module hpt_back #(
    parameter int SLOTS   = hpt_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS = hpt_pkg::ID_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    input  hpt_pkg::item_t           job_item,
    input  logic [$clog2(SLOTS)-1:0] job_home,
    output logic                     job_pop,
    output logic                     init_busy,
    output hpt_pkg::result_t         result,
    output logic                     empty,
    input  logic                     pop
);
    import hpt_pkg::*;

    localparam int SB = $clog2(SLOTS);
    localparam int CB = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [SB-1:0] pos_reg, pos_next;
    logic [SB-1:0] idx_reg, idx_next;
    logic [SB-1:0] old_pos_reg, old_pos_next;
    logic [31:0]   old_time_reg, old_time_next;
    logic [CB-1:0] count_reg, count_next;
    logic [31:0]   hits_reg, hits_next;
    logic [31:0]   miss_reg, miss_next;
    item_t         cur_reg;
    result_t       res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    entry_t             mem_q [SLOTS];
    logic [ID_BITS-1:0] id_q [SLOTS];
    entry_t             rd_entry;
    logic [ID_BITS-1:0] rd_id;

    logic               rd_en, wr_en;
    logic [SB-1:0]      rd_addr, wr_addr;
    entry_t             wr_entry;
    logic [ID_BITS-1:0] wr_id;

    logic          key_match, last, older;
    logic [SB-1:0] step_pos;

    assign key_match = rd_entry.valid && rd_entry.m == cur_reg.dim_m
                    && rd_entry.n == cur_reg.dim_n && rd_entry.k == cur_reg.dim_k
                    && rd_entry.t == cur_reg.thread_count && rd_entry.e == cur_reg.tile_edge;
    assign last     = idx_reg == SB'(SLOTS - 1);
    assign step_pos = pos_reg + SB'(1);
    assign older    = (idx_reg == '0) || (rd_entry.stamp < old_time_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        old_pos_next   = old_pos_reg;
        old_time_next  = old_time_reg;
        count_next     = count_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        job_pop        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = step_pos;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_entry       = '0;
        wr_id          = ID_BITS'(cur_reg.kernel_id);
        res_next.hit      = 1'b0;
        res_next.found_id = '0;
        res_next.slot     = '0;
        res_next.evicted  = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                idx_next = idx_reg + SB'(1);
                if (last)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                    if (state_reg == ST_CLEAR)
                    begin
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_IDLE:
            begin
                if (job_valid && !res_valid_reg)
                begin
                    job_pop  = 1'b1;
                    pos_next = job_home;
                    idx_next = '0;
                    case (job_item.func)
                        FUNC_LOOKUP, FUNC_INSERT:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = job_home;
                            state_next = ST_PROBE;
                        end
                        FUNC_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                if (cur_reg.func == FUNC_LOOKUP)
                begin
                    if (key_match)
                    begin
                        res_next.hit      = 1'b1;
                        res_next.found_id = FID_W'(rd_id);
                        res_next.slot     = SLOT_W'(pos_reg);
                        hits_next         = hits_reg + 32'd1;
                        res_valid_next    = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else if (last)
                    begin
                        miss_next      = miss_reg + 32'd1;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        pos_next = step_pos;
                        idx_next = idx_reg + SB'(1);
                    end
                end
                else
                begin
                    wr_entry.valid = 1'b1;
                    wr_entry.m     = cur_reg.dim_m;
                    wr_entry.n     = cur_reg.dim_n;
                    wr_entry.k     = cur_reg.dim_k;
                    wr_entry.t     = cur_reg.thread_count;
                    wr_entry.e     = cur_reg.tile_edge;
                    wr_entry.stamp = cur_reg.now_time;
                    if (older)
                    begin
                        old_pos_next  = pos_reg;
                        old_time_next = rd_entry.stamp;
                    end
                    if (!rd_entry.valid)
                    begin
                        wr_en          = 1'b1;
                        count_next     = count_reg + CB'(1);
                        res_next.slot  = SLOT_W'(pos_reg);
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (last)
                    begin
                        // table full: replace the oldest entry seen on the ring
                        wr_en            = 1'b1;
                        wr_addr          = old_pos_next;
                        res_next.slot    = SLOT_W'(old_pos_next);
                        res_next.evicted = 1'b1;
                        res_valid_next   = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        pos_next = step_pos;
                        idx_next = idx_reg + SB'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.valid_count = COUNT_W'(count_next);
        res_next.hit_total   = hits_next;
        res_next.miss_total  = miss_next;
        if (!(res_valid_next && !(res_valid_reg && !pop)))
        begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            count_reg     <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        old_pos_reg  <= old_pos_next;
        old_time_reg <= old_time_next;
        res_reg      <= res_next;
        if (job_pop)
        begin
            cur_reg <= job_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_entry;
            id_q[wr_addr]  <= wr_id;
        end
        if (rd_en)
        begin
            rd_entry <= mem_q[rd_addr];
            rd_id    <= id_q[rd_addr];
        end
    end

    assign init_busy = state_reg == ST_INIT;
    assign result    = res_reg;
    assign empty     = !res_valid_reg;

endmodule

// ===== src/hashed_probe_table_oldest_evict.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------
// item      | in        | push / full                | hpt_pkg::item_t
// result    | out       | pop / empty                | hpt_pkg::result_t
//
// hashing steps through the KEY_PARTS key words in the front, then takes one queue slot; a lookup or
// insert probes one slot per cycle through the single read port of the slot
// memory; a clear sweeps all SLOTS entries
// after reset the back sweeps all SLOTS entries with full high
// a result held on the port stalls the back; the front and queue keep taking items until the queue fills

module hashed_probe_table_oldest_evict #(
    parameter int SLOTS   = hpt_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS = hpt_pkg::ID_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  hpt_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output hpt_pkg::result_t result
);
    import hpt_pkg::*;

    localparam int SB = $clog2(SLOTS);
    localparam int JW = $bits(item_t) + SB;

    logic          front_busy, init_busy;
    logic          job_push, job_full, job_pop, job_empty;
    item_t         job_item_f, job_item_b;
    logic [SB-1:0] job_home_f, job_home_b;

    assign full = front_busy || init_busy;

    hpt_front #(.SLOTS(SLOTS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push && !init_busy),
        .item     (item),
        .busy     (front_busy),
        .job_push (job_push),
        .job_item (job_item_f),
        .job_home (job_home_f),
        .job_full (job_full)
    );

    hpt_fifo #(.W(JW), .DEPTH(2)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_push),
        .wdata ({job_item_f, job_home_f}),
        .full  (job_full),
        .rd    (job_pop),
        .rdata ({job_item_b, job_home_b}),
        .empty (job_empty)
    );

    hpt_back #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job_item  (job_item_b),
        .job_home  (job_home_b),
        .job_pop   (job_pop),
        .init_busy (init_busy),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.valid_count <= COUNT_W'(SLOTS))
        else $error("valid count above table size");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.evicted) |-> result.valid_count == COUNT_W'(SLOTS))
        else $error("eviction while table not full");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.hit) |-> !result.evicted)
        else $error("hit and evicted together");

    a_init_full: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> full)
        else $error("item taken during table sweep");

endmodule

// ===== sim/hashed_probe_table_oldest_evict_tb.sv =====
`timescale 1ns / 1ps

module hashed_probe_table_oldest_evict_tb;
    import hpt_pkg::*;

    localparam int NSLOT = 1024;
    localparam logic [63:0] PRIME = 64'd1099511628211;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    logic    full;
    logic    empty;
    item_t   item = '0;
    result_t result;

    hashed_probe_table_oldest_evict u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result)
    );

    always #5 clk = ~clk;

    // table shadow
    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_m [NSLOT];
    logic [31:0] tbl_n [NSLOT];
    logic [31:0] tbl_k [NSLOT];
    logic [15:0] tbl_t [NSLOT];
    logic [15:0] tbl_e [NSLOT];
    logic [7:0]  tbl_id [NSLOT];
    logic [31:0] tbl_stamp [NSLOT];
    logic [10:0] live_entries = '0;
    logic [31:0] hits_so_far = '0;
    logic [31:0] misses_so_far = '0;

    item_t   pending_items [$];
    result_t expected_results [$];
    item_t   recent_keys [$];
    int      errors = 0;
    bit      stim_done = 0;
    bit      quiet = 0;       // no idling in the last part
    bit      hold_sink = 0;   // long receiver hold-off
    logic [31:0] clock_stamp = 32'd1000;

    initial begin
        for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    end

    function automatic logic [9:0] home_slot(item_t it);
        logic [63:0] h;
        h = 64'hCBF2_9CE4_8422_2325;
        h = (h ^ {32'd0, it.dim_m}) * PRIME;
        h = (h ^ {32'd0, it.dim_n}) * PRIME;
        h = (h ^ {32'd0, it.dim_k}) * PRIME;
        h = (h ^ {48'd0, it.thread_count}) * PRIME;
        h = (h ^ {48'd0, it.tile_edge}) * PRIME;
        return h[9:0];
    endfunction

    function automatic result_t table_step(item_t it);
        result_t r;
        logic [9:0] home, p, old_p;
        logic [31:0] old_ts;
        bit got_empty, have_old;
        r = '0;
        home = home_slot(it);
        got_empty = 0;
        have_old = 0;
        old_p = '0;
        old_ts = '0;
        if (it.func == FUNC_LOOKUP) begin
            for (int i = 0; i < NSLOT; i++)
            begin
                p = home + 10'(i);
                if (tbl_valid[p] && tbl_m[p] == it.dim_m && tbl_n[p] == it.dim_n &&
                    tbl_k[p] == it.dim_k && tbl_t[p] == it.thread_count &&
                    tbl_e[p] == it.tile_edge)
                begin
                    r.hit = 1'b1;
                    r.found_id = tbl_id[p];
                    r.slot = p;
                    break;
                end
            end
            if (r.hit) hits_so_far++;
            else misses_so_far++;
        end else if (it.func == FUNC_INSERT) begin
            p = home;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!tbl_valid[home + 10'(i)])
                begin
                    p = home + 10'(i);
                    got_empty = 1;
                    break;
                end
                if (!have_old || tbl_stamp[home + 10'(i)] < old_ts)
                begin
                    have_old = 1;
                    old_ts = tbl_stamp[home + 10'(i)];
                    old_p = home + 10'(i);
                end
            end
            if (!got_empty)
            begin
                p = old_p;
                r.evicted = 1'b1;
            end else
                live_entries++;
            tbl_valid[p] = 1'b1;
            tbl_m[p] = it.dim_m;
            tbl_n[p] = it.dim_n;
            tbl_k[p] = it.dim_k;
            tbl_t[p] = it.thread_count;
            tbl_e[p] = it.tile_edge;
            tbl_id[p] = it.kernel_id;
            tbl_stamp[p] = it.now_time;
            r.slot = p;
        end else if (it.func == FUNC_CLEAR) begin
            for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
            live_entries = '0;
        end
        r.valid_count = live_entries;
        r.hit_total = hits_so_far;
        r.miss_total = misses_so_far;
        return r;
    endfunction

    function automatic item_t random_key();
        item_t it;
        it.func = FUNC_LOOKUP;
        // small key values collide more often, full-range ones cover every bit
        it.dim_m = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 64);
        it.dim_n = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 64);
        it.dim_k = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 64);
        it.thread_count = 16'($urandom_range(0, 65535));
        it.tile_edge = 16'($urandom_range(0, 65535));
        it.kernel_id = 8'($urandom_range(0, 255));
        it.now_time = $urandom();
        return it;
    endfunction

    task automatic add_item(item_t it);
        pending_items.push_back(it);
    endtask

    // driver
    int src_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                expected_results.push_back(table_step(item));
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                if (!(push && full)) push <= 1'b0;
            end else if (push && full) begin
                // hold the offer
            end else if (pending_items.size() > 0 &&
                         pending_items[0].func === 2'bxx) begin
                push <= 1'b0;
            end else if (pending_items.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    src_gap <= $urandom_range(1, 9);
                    push <= 1'b0;
                end else begin
                    item <= pending_items.pop_front();
                    push <= 1'b1;
                end
            end else begin
                push <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // monitor
    int sink_gap = 0;
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: %p", result);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (result.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, result.hit);
                        errors++;
                    end
                    if (result.found_id !== want.found_id)
                    begin
                        $error("found_id: expected %0d, got %0d", want.found_id,
                               result.found_id);
                        errors++;
                    end
                    if (result.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, result.slot);
                        errors++;
                    end
                    if (result.evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", want.evicted,
                               result.evicted);
                        errors++;
                    end
                    if (result.valid_count !== want.valid_count)
                    begin
                        $error("valid_count: expected %0d, got %0d", want.valid_count,
                               result.valid_count);
                        errors++;
                    end
                    if (result.hit_total !== want.hit_total)
                    begin
                        $error("hit_total: expected %0d, got %0d", want.hit_total,
                               result.hit_total);
                        errors++;
                    end
                    if (result.miss_total !== want.miss_total)
                    begin
                        $error("miss_total: expected %0d, got %0d", want.miss_total,
                               result.miss_total);
                        errors++;
                    end
                end
            end
            if (hold_sink)
                pop <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(1, 9);
                pop <= 1'b0;
            end else
                pop <= 1'b1;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        @(posedge rst_n);
        repeat (200) @(posedge clk);
        hold_sink <= 1'b1;
        repeat (6000) @(posedge clk);
        hold_sink <= 1'b0;
    end

    // sender pause: a marker item with an unknown func is dropped once everything is back
    always @(posedge clk)
    begin
        if (rst_n && !push && src_gap == 0 && pending_items.size() > 0 &&
            pending_items[0].func === 2'bxx && expected_results.size() == 0 && empty)
        begin
            void'(pending_items.pop_front());
        end
    end

    function automatic item_t next_item();
        item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (recent_keys.size() > 0 && pick < 45)
            it = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else
            it = random_key();
        it.kernel_id = 8'($urandom_range(0, 255));
        clock_stamp = clock_stamp + $urandom_range(0, 3);
        it.now_time = ($urandom_range(0, 19) == 0) ? $urandom() : clock_stamp;
        if (pick < 40) it.func = FUNC_LOOKUP;
        else if (pick < 96) it.func = FUNC_INSERT;
        else if (pick < 98) it.func = FUNC_CLEAR;
        else it.func = FUNC_SPARE;
        if (it.func == FUNC_INSERT)
        begin
            recent_keys.push_back(it);
            if (recent_keys.size() > 40) void'(recent_keys.pop_front());
        end
        return it;
    endfunction

    initial begin
        item_t it, pause_mark;
        pause_mark = 'x;
        // directed
        it = '0;
        add_item(it);                           // lookup on empty table
        it.func = FUNC_INSERT; it.kernel_id = 8'd7; it.now_time = 32'd5;
        add_item(it);
        it.kernel_id = 8'd9; it.now_time = 32'd6;
        add_item(it);                           // duplicate takes another slot
        it.func = FUNC_LOOKUP;
        add_item(it);
        it = '1; it.func = FUNC_INSERT;         // all-ones key, id, stamp
        add_item(it);
        it.func = FUNC_LOOKUP;
        add_item(it);
        it.func = FUNC_SPARE;
        add_item(it);                           // unused code
        it = '0; it.func = FUNC_CLEAR;
        add_item(it);
        it.func = FUNC_LOOKUP;
        add_item(it);                           // miss after clear
        // a run of inserts with equal stamps at the start
        for (int i = 0; i < 40; i++)
        begin
            it = random_key();
            it.func = FUNC_INSERT;
            it.dim_m = i;
            it.now_time = (i < 8) ? 32'd3 : 32'd100 + i;
            add_item(it);
        end
        it.func = FUNC_LOOKUP;
        add_item(it);
        add_item(pause_mark);
        it = '0; it.func = FUNC_CLEAR;
        add_item(it);
        for (int i = 0; i < 530; i++)
        begin
            if (i == 300) add_item(pause_mark);
            add_item(next_item());
        end
        @(posedge stim_done);
        wait (expected_results.size() == 0);
        repeat (2200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // last part of the run goes without idling
    initial begin
        wait (pending_items.size() > 0);
        wait (pending_items.size() < 120);
        quiet = 1;
    end

    initial begin
        #60ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
